// File: sv/aemp_pkg.sv
`timescale 1ns / 1ps

package aemp_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_ROW_ZERO  = 3'd0;
  localparam logic [2:0] REG_ROW_ONE   = 3'd1;
  localparam logic [2:0] REG_ROW_TWO   = 3'd2;
  localparam logic [2:0] REG_TIME_STEP = 3'd3;

  localparam logic signed [15:0] TIME_STEP_RESET = 16'sd8192;

  // Number of fraction bits dropped when rounding
  localparam int unsigned RND_SHIFT = 14;

  typedef logic signed [47:0] prod48_t;
  typedef logic signed [31:0] prod32_t;

  // Transform rows: [15:0] r0, [31:16] r1, [47:32] r2, [63:48] t (Q8.8)
  typedef logic [2:0][63:0] rows_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] size_w;
    logic signed [31:0] size_l;
    logic signed [31:0] size_h;
    logic signed [15:0] yaw_sin;
    logic signed [15:0] yaw_cos;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic signed [31:0] out_l;
    logic signed [31:0] out_h;
    logic signed [15:0] slot_sin;
    logic signed [15:0] slot_cos;
    logic signed [31:0] out_vx;
    logic signed [31:0] out_vy;
    logic signed [31:0] out_vz;
  } out_t;

  // Predicted centre plus the fields that ride along
  typedef struct packed {
    logic [2:0][31:0] cen;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] size;
    logic signed [15:0] yaw_sin;
    logic signed [15:0] yaw_cos;
  } pred_t;

  // Partial products of the transform, row-major
  typedef struct packed {
    logic [2:0][2:0][47:0] cen_p;
    logic [2:0][2:0][47:0] vel_p;
    logic [1:0][1:0][31:0] yaw_p;
    logic [2:0][31:0]      size;
  } prod_t;

  // Saturate a 38-bit two's complement value to 32 bits
  function automatic logic [31:0] sat_q16(input logic [37:0] x);
    logic [31:0] res;
    if (!x[37] && (|x[36:31])) begin
      res = 32'h7FFF_FFFF;
    end else if (x[37] && !(&x[36:31])) begin
      res = 32'h8000_0000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

  // Saturate a 20-bit two's complement value to 16 bits
  function automatic logic [15:0] sat_q14(input logic [19:0] x);
    logic [15:0] res;
    if (!x[19] && (|x[18:15])) begin
      res = 16'h7FFF;
    end else if (x[19] && !(&x[18:15])) begin
      res = 16'h8000;
    end else begin
      res = x[15:0];
    end
    return res;
  endfunction

endpackage

// File: sv/aemp_predict.sv
`timescale 1ns / 1ps

// Two stages: velocity times dt, then rounded add onto the centre
module aemp_predict (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic signed [15:0]      dt,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  aemp_pkg::in_t           up_data,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output aemp_pkg::pred_t         dn_data
);

  typedef struct packed {
    logic [2:0][47:0] mv;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] size;
    logic signed [15:0] yaw_sin;
    logic signed [15:0] yaw_cos;
  } mul_t;

  logic            s1_valid_r;
  logic            s1_ready;
  mul_t            s1_r;
  mul_t            s1_nxt;
  logic            s2_valid_r;
  logic            s2_ready;
  aemp_pkg::pred_t s2_r;
  aemp_pkg::pred_t s2_nxt;

  logic [2:0][48:0] mv_rnd;
  logic [2:0][35:0] cen_sum;

  assign s2_ready = !s2_valid_r || dn_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign up_ready = s1_ready;

  // Stage 1: v * dt, Q16.16 x Q2.14
  always_comb begin
    s1_nxt.pos[0]  = up_data.pos_x;
    s1_nxt.pos[1]  = up_data.pos_y;
    s1_nxt.pos[2]  = up_data.pos_z;
    s1_nxt.vel[0]  = up_data.vel_x;
    s1_nxt.vel[1]  = up_data.vel_y;
    s1_nxt.vel[2]  = up_data.vel_z;
    s1_nxt.size[0] = up_data.size_w;
    s1_nxt.size[1] = up_data.size_l;
    s1_nxt.size[2] = up_data.size_h;
    s1_nxt.yaw_sin = up_data.yaw_sin;
    s1_nxt.yaw_cos = up_data.yaw_cos;
    for (int i = 0; i < 3; i++) begin
      s1_nxt.mv[i] = aemp_pkg::prod48_t'($signed(s1_nxt.vel[i]) * dt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && up_valid) begin
      s1_r <= s1_nxt;
    end
  end

  // Stage 2: round half up, add to position, saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mv_rnd[i]  = {s1_r.mv[i][47], s1_r.mv[i]} + 49'd8192;
      cen_sum[i] = {{4{s1_r.pos[i][31]}}, s1_r.pos[i]}
                 + {mv_rnd[i][48], mv_rnd[i][48:aemp_pkg::RND_SHIFT]};
      s2_nxt.cen[i] = aemp_pkg::sat_q16({{2{cen_sum[i][35]}}, cen_sum[i]});
    end
    s2_nxt.vel     = s1_r.vel;
    s2_nxt.size    = s1_r.size;
    s2_nxt.yaw_sin = s1_r.yaw_sin;
    s2_nxt.yaw_cos = s1_r.yaw_cos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_data  = s2_r;

endmodule

// File: sv/aemp_product.sv
`timescale 1ns / 1ps

// Stage 3: rotation coefficient products for centre, velocity and heading
module aemp_product (
  input  logic              clk,
  input  logic              rst_n,
  input  aemp_pkg::rows_t   rows,
  input  logic              up_valid,
  output logic              up_ready,
  input  aemp_pkg::pred_t   up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output aemp_pkg::prod_t   dn_data
);

  logic            valid_r;
  aemp_pkg::prod_t prod_r;
  aemp_pkg::prod_t prod_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_nxt.cen_p[r][k] = aemp_pkg::prod48_t'(
          $signed(rows[r][16*k +: 16]) * $signed(up_data.cen[k]));
        prod_nxt.vel_p[r][k] = aemp_pkg::prod48_t'(
          $signed(rows[r][16*k +: 16]) * $signed(up_data.vel[k]));
      end
    end
    // Heading pair (cos, sin) through the first two columns of rows 0 and 1
    for (int r = 0; r < 2; r++) begin
      prod_nxt.yaw_p[r][0] = aemp_pkg::prod32_t'(
        $signed(rows[r][15:0]) * up_data.yaw_cos);
      prod_nxt.yaw_p[r][1] = aemp_pkg::prod32_t'(
        $signed(rows[r][31:16]) * up_data.yaw_sin);
    end
    prod_nxt.size = up_data.size;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      prod_r <= prod_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = prod_r;

endmodule

// File: sv/aemp_accum.sv
`timescale 1ns / 1ps

// Stage 4: sum products, add translation, round and saturate; output register
module aemp_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  aemp_pkg::rows_t   rows,
  input  logic              up_valid,
  output logic              up_ready,
  input  aemp_pkg::prod_t   up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output aemp_pkg::out_t    dn_data
);

  logic             valid_r;
  aemp_pkg::out_t   res_r;
  aemp_pkg::out_t   res_nxt;

  logic [2:0][51:0] cen_acc;
  logic [2:0][51:0] vel_acc;
  logic [2:0][31:0] cen_sat;
  logic [2:0][31:0] vel_sat;
  logic [1:0][33:0] yaw_acc;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      // translation Q8.8 lifted to Q.30
      cen_acc[r] = {{4{up_data.cen_p[r][0][47]}}, up_data.cen_p[r][0]}
                 + {{4{up_data.cen_p[r][1][47]}}, up_data.cen_p[r][1]}
                 + {{4{up_data.cen_p[r][2][47]}}, up_data.cen_p[r][2]}
                 + {{14{rows[r][63]}}, rows[r][63:48], 22'd0}
                 + 52'd8192;
      vel_acc[r] = {{4{up_data.vel_p[r][0][47]}}, up_data.vel_p[r][0]}
                 + {{4{up_data.vel_p[r][1][47]}}, up_data.vel_p[r][1]}
                 + {{4{up_data.vel_p[r][2][47]}}, up_data.vel_p[r][2]}
                 + 52'd8192;
      cen_sat[r] = aemp_pkg::sat_q16(cen_acc[r][51:aemp_pkg::RND_SHIFT]);
      vel_sat[r] = aemp_pkg::sat_q16(vel_acc[r][51:aemp_pkg::RND_SHIFT]);
    end
    for (int r = 0; r < 2; r++) begin
      yaw_acc[r] = {{2{up_data.yaw_p[r][0][31]}}, up_data.yaw_p[r][0]}
                 + {{2{up_data.yaw_p[r][1][31]}}, up_data.yaw_p[r][1]}
                 + 34'd8192;
    end
    res_nxt.out_x    = cen_sat[0];
    res_nxt.out_y    = cen_sat[1];
    res_nxt.out_z    = cen_sat[2];
    res_nxt.out_w    = up_data.size[0];
    res_nxt.out_l    = up_data.size[1];
    res_nxt.out_h    = up_data.size[2];
    // row 0 result goes to the sin slot, row 1 to the cos slot
    res_nxt.slot_sin = aemp_pkg::sat_q14(yaw_acc[0][33:aemp_pkg::RND_SHIFT]);
    res_nxt.slot_cos = aemp_pkg::sat_q14(yaw_acc[1][33:aemp_pkg::RND_SHIFT]);
    res_nxt.out_vx   = vel_sat[0];
    res_nxt.out_vy   = vel_sat[1];
    res_nxt.out_vz   = vel_sat[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      res_r <= res_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = res_r;

endmodule

// File: sv/anchor_ego_motion_projection.sv
`timescale 1ns / 1ps
// Pipeline: four register stages (v*dt, centre predict, coefficient products,
//   accumulate/round/saturate) between the input and the result transaction.
// Throughput: one transaction per cycle; each stage holds under backpressure.
// Reset (rst_n low, synchronous): all stages empty, rows cleared to zero,
//   time step set to 0.5 s (8192 in Q2.14).
module anchor_ego_motion_projection (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  aemp_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output aemp_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [63:0]     cfg_data
);

  aemp_pkg::rows_t    rows_r;
  logic signed [15:0] dt_r;

  logic               pred_valid;
  logic               pred_ready;
  aemp_pkg::pred_t    pred_data;
  logic               prod_valid;
  logic               prod_ready;
  aemp_pkg::prod_t    prod_data;

  // Configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= '0;
      dt_r   <= aemp_pkg::TIME_STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aemp_pkg::REG_ROW_ZERO:  rows_r[0] <= cfg_data;
        aemp_pkg::REG_ROW_ONE:   rows_r[1] <= cfg_data;
        aemp_pkg::REG_ROW_TWO:   rows_r[2] <= cfg_data;
        aemp_pkg::REG_TIME_STEP: dt_r      <= $signed(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  aemp_predict u_predict (
    .clk      (clk),
    .rst_n    (rst_n),
    .dt       (dt_r),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (pred_valid),
    .dn_ready (pred_ready),
    .dn_data  (pred_data)
  );

  aemp_product u_product (
    .clk      (clk),
    .rst_n    (rst_n),
    .rows     (rows_r),
    .up_valid (pred_valid),
    .up_ready (pred_ready),
    .up_data  (pred_data),
    .dn_valid (prod_valid),
    .dn_ready (prod_ready),
    .dn_data  (prod_data)
  );

  aemp_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .rows     (rows_r),
    .up_valid (prod_valid),
    .up_ready (prod_ready),
    .up_data  (prod_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

endmodule
